/* design/smlc_pkg.sv */
// Shared constants, types and helpers for the substring match line/column unit.
`default_nettype none

package smlc_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int MAX_LINE_DEF    = 2048;

    localparam int BYTE_W = 8;
    localparam int LINE_W = 32;
    localparam int COL_W  = 12;
    localparam int LEN_W  = 5;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 2;
    localparam int PAT_BYTES = 16;

    localparam logic [IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [IDX_W-1:0] REG_PAT_LEN  = 2'd2;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;
    localparam logic [LINE_W-1:0] LINE_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              used;
        logic [BYTE_W-1:0] pat;
    } t_cell_ctl;

    function automatic logic [BYTE_W-1:0] sel_byte(
        input logic [PAT_BYTES*BYTE_W-1:0] pat,
        input logic [3:0]                  idx
    );
        sel_byte = pat[idx*BYTE_W +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

/* design/smlc_cell.sv */
// One window cell: holds one recent text byte and compares its next value to a pattern byte.
`default_nettype none

module smlc_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_shift,
    input  wire logic [smlc_pkg::BYTE_W-1:0]  i_byte_in,
    input  wire smlc_pkg::t_cell_ctl          i_ctl,
    output logic      [smlc_pkg::BYTE_W-1:0]  o_byte,
    output logic                              o_eq
);

    logic [smlc_pkg::BYTE_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte_in;
        end
    end

    assign o_byte = r_byte;
    assign o_eq   = !i_ctl.used || (i_byte_in == i_ctl.pat);

endmodule

`default_nettype wire

/* design/substring_match_line_column_unit.sv */
// Top level of the streaming pattern search with line and column reporting.
//
// Input channel: one text byte per transfer (i_in_valid / o_in_ready).
// Output channel: one match per transfer (o_out_valid / i_out_ready) carrying the
// 1-based line number and the 1-based start column of the match.
// A match is reported for the byte that completes it; the result is registered and
// appears in the cycle after that byte's transfer, held in an output register.
// Throughput is one byte per cycle while the receiver does not stall: the pattern
// window is a chain of MAX_PATTERN cells that all compare in the same cycle, and
// the line/column counters update in a single step.
// While a result waits in the output register and the receiver stalls, input is
// held off; when the receiver takes it, a new byte is accepted in the same cycle.
// Configuration writes (pattern bytes low/high, pattern length) are to be made only
// while the block is idle; the user is bound by this, the block does not enforce it.
// Reset (synchronous, active low) clears the counters, the skip count, the
// output valid flag and sets the pattern to all zero with length one.
`default_nettype none

module substring_match_line_column_unit #(
    parameter int MAX_PATTERN = smlc_pkg::MAX_PATTERN_DEF,
    parameter int MAX_LINE    = smlc_pkg::MAX_LINE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [smlc_pkg::BYTE_W-1:0]   i_in_text_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [smlc_pkg::LINE_W-1:0]   o_out_line_number,
    output logic      [smlc_pkg::COL_W-1:0]    o_out_start_column,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [smlc_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [smlc_pkg::CFG_W-1:0]    i_cfg_wdata
);

    localparam int BIL_MAX  = MAX_LINE + MAX_PATTERN;
    localparam int BIL_W    = $clog2(BIL_MAX + 1);
    localparam int COLX_W   = (BIL_W > smlc_pkg::COL_W) ? BIL_W : smlc_pkg::COL_W;
    localparam int LEN_W    = smlc_pkg::LEN_W;
    localparam int BYTE_W   = smlc_pkg::BYTE_W;
    localparam int LINE_W   = smlc_pkg::LINE_W;
    localparam int COL_W    = smlc_pkg::COL_W;

    // Configuration registers
    logic [smlc_pkg::CFG_W-1:0] r_pat_low;
    logic [smlc_pkg::CFG_W-1:0] r_pat_high;
    logic [LEN_W-1:0]           r_pat_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= LEN_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                smlc_pkg::REG_PAT_LOW:  r_pat_low  <= i_cfg_wdata;
                smlc_pkg::REG_PAT_HIGH: r_pat_high <= i_cfg_wdata;
                smlc_pkg::REG_PAT_LEN:  r_pat_len  <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [LEN_W-1:0] len;
    always_comb begin
        if (r_pat_len == '0) begin
            len = LEN_W'(1);
        end else if (r_pat_len > LEN_W'(MAX_PATTERN)) begin
            len = LEN_W'(MAX_PATTERN);
        end else begin
            len = r_pat_len;
        end
    end

    logic [smlc_pkg::PAT_BYTES*BYTE_W-1:0] pat_all;
    assign pat_all = {r_pat_high, r_pat_low};

    // Handshake
    logic r_out_valid;
    logic in_xfer;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Window chain
    logic [BYTE_W-1:0] cell_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_eq;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [BYTE_W-1:0]   byte_in;
        logic [LEN_W-1:0]    pidx;
        smlc_pkg::t_cell_ctl ctl;

        if (k == 0) begin : g_head
            assign byte_in = i_in_text_byte;
        end else begin : g_link
            assign byte_in = cell_byte[k-1];
        end

        assign pidx = len - LEN_W'(1) - LEN_W'(k);
        assign ctl  = {LEN_W'(k) < len, smlc_pkg::sel_byte(pat_all, pidx[3:0])};

        smlc_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (in_xfer),
            .i_byte_in (byte_in),
            .i_ctl     (ctl),
            .o_byte    (cell_byte[k]),
            .o_eq      (cell_eq[k])
        );
    end

    // Line and column tracking
    logic [BIL_W-1:0]  r_bil;
    logic [LINE_W-1:0] r_lines;
    logic [LEN_W-1:0]  r_skip;

    logic [BIL_W-1:0]  bil_inc;
    logic [BIL_W-1:0]  col;
    logic [BIL_W-1:0]  col_sat;
    logic [COLX_W-1:0] col_x;
    logic [LINE_W-1:0] line_inc;
    logic              hit;
    logic              is_nl;

    assign bil_inc  = (r_bil < BIL_W'(BIL_MAX)) ? r_bil + BIL_W'(1) : r_bil;
    assign col      = bil_inc - BIL_W'(len) + BIL_W'(1);
    assign col_sat  = (col > BIL_W'(MAX_LINE)) ? BIL_W'(MAX_LINE) : col;
    assign col_x    = COLX_W'(col_sat);
    assign line_inc = (r_lines != smlc_pkg::LINE_MAX) ? r_lines + LINE_W'(1) : r_lines;
    assign hit      = (r_skip == '0) && (bil_inc >= BIL_W'(len)) && (&cell_eq);
    assign is_nl    = (i_in_text_byte == smlc_pkg::NEWLINE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bil   <= '0;
            r_lines <= '0;
            r_skip  <= '0;
        end else if (in_xfer) begin
            if (is_nl) begin
                r_bil   <= '0;
                r_skip  <= '0;
                r_lines <= line_inc;
            end else begin
                r_bil <= bil_inc;
                if (r_skip != '0) begin
                    r_skip <= r_skip - LEN_W'(1);
                end else if (hit) begin
                    r_skip <= len - LEN_W'(1);
                end
            end
        end
    end

    // Output register
    logic [LINE_W-1:0] r_out_line;
    logic [COL_W-1:0]  r_out_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && hit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && hit) begin
            r_out_line <= line_inc;
            r_out_col  <= col_x[COL_W-1:0];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_line_number  = r_out_line;
    assign o_out_start_column = r_out_col;

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_line != '0))
        else $error("match reported on line zero");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while result is stalled");

    a_newline_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && is_nl) |=> ((r_bil == '0) && (r_skip == '0)))
        else $error("newline did not clear column and skip");

    a_no_hit_in_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip != '0) |-> !hit)
        else $error("match raised inside skip window");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Testbench for the substring match unit: directed and random text streams checked by a line/column predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W      = smlc_pkg::BYTE_W;
    localparam int LINE_W      = smlc_pkg::LINE_W;
    localparam int COL_W       = smlc_pkg::COL_W;
    localparam int LEN_W       = smlc_pkg::LEN_W;
    localparam int CFG_W       = smlc_pkg::CFG_W;
    localparam int IDX_W       = smlc_pkg::IDX_W;
    localparam int MAX_PAT     = smlc_pkg::MAX_PATTERN_DEF;
    localparam int MAX_COL     = smlc_pkg::MAX_LINE_DEF;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int LONG_HOLD   = 200;
    localparam int PHASE_ITEMS = 216;
    localparam int NUM_PHASES  = 9;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    typedef struct packed {
        logic [LINE_W-1:0] line_no;
        logic [COL_W-1:0]  column;
    } t_match;

    class t_match_predictor;
        logic [CFG_W-1:0]  pat_low;
        logic [CFG_W-1:0]  pat_high;
        logic [LEN_W-1:0]  pat_len;
        logic [BYTE_W-1:0] window [MAX_PAT];
        int unsigned       line_bytes;
        logic [LINE_W-1:0] lines_done;
        int unsigned       skip;
        t_match            expected_matches [$];
        int                mismatches;

        function new();
            pat_low    = '0;
            pat_high   = '0;
            pat_len    = LEN_W'(1);
            foreach (window[k]) window[k] = '0;
            line_bytes = 0;
            lines_done = '0;
            skip       = 0;
            mismatches = 0;
        endfunction

        function void note_config(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                smlc_pkg::REG_PAT_LOW:  pat_low  = data;
                smlc_pkg::REG_PAT_HIGH: pat_high = data;
                smlc_pkg::REG_PAT_LEN:  pat_len  = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b);
            logic [2*CFG_W-1:0] pat;
            int unsigned        len;
            int unsigned        start;
            bit                 hit;
            t_match             m;
            pat = {pat_high, pat_low};
            len = (pat_len == 0) ? 1 : (pat_len > MAX_PAT) ? MAX_PAT : pat_len;
            for (int k = MAX_PAT - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = b;
            if (line_bytes < MAX_COL + MAX_PAT) line_bytes++;
            hit = 1'b0;
            if (skip > 0) begin
                skip--;
            end else if (line_bytes >= len) begin
                hit = 1'b1;
                for (int k = 0; k < len; k++)
                    if (pat[k*BYTE_W +: BYTE_W] != window[len-1-k]) hit = 1'b0;
            end
            if (hit) begin
                start     = line_bytes - len + 1;
                m.column  = (start > MAX_COL) ? COL_W'(MAX_COL) : COL_W'(start);
                m.line_no = (lines_done == smlc_pkg::LINE_MAX) ? lines_done : lines_done + 1;
                expected_matches.push_back(m);
                skip = len - 1;
            end
            if (b == smlc_pkg::NEWLINE) begin
                line_bytes = 0;
                skip       = 0;
                if (lines_done != smlc_pkg::LINE_MAX) lines_done++;
            end
        endfunction

        function void check_match(logic [LINE_W-1:0] line_no, logic [COL_W-1:0] column);
            t_match e;
            if (expected_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected match: line %0d column %0d", line_no, column);
            end else begin
                e = expected_matches.pop_front();
                if (e.line_no !== line_no || e.column !== column) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"match mismatch: expected line %0d column %0d, ",
                                  "got line %0d column %0d"},
                                 e.line_no, e.column, line_no, column);
                end
            end
        endfunction

        function int pending_count();
            return expected_matches.size();
        endfunction
    endclass

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic [BYTE_W-1:0]   i_in_text_byte = '0;
    logic                i_out_ready    = 1'b0;
    logic                i_cfg_wr_en    = 1'b0;
    logic [IDX_W-1:0]    i_cfg_index    = '0;
    logic [CFG_W-1:0]    i_cfg_wdata    = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [LINE_W-1:0]   o_out_line_number;
    logic [COL_W-1:0]    o_out_start_column;

    t_match_predictor    predictor;
    logic [BYTE_W-1:0]   text_q [$];
    logic [BYTE_W-1:0]   pat_b [MAX_PAT];
    int unsigned         gen_len = 1;
    bit                  long_hold_req = 1'b0;
    int unsigned         cycle_count;

    substring_match_line_column_unit u_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                predictor.check_match(o_out_line_number, o_out_start_column);
            if (i_in_valid && o_in_ready)
                predictor.take_byte(i_in_text_byte);
        end
    end

    task automatic put_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        predictor.note_config(idx, data);
    endtask

    task automatic load_pattern(logic [LEN_W-1:0] len_val, bit stray);
        logic [CFG_W-1:0] low;
        logic [CFG_W-1:0] high;
        for (int k = 0; k < 8; k++) begin
            low[k*BYTE_W +: BYTE_W]  = pat_b[k];
            high[k*BYTE_W +: BYTE_W] = pat_b[k+8];
        end
        if (stray) put_reg(REG_UNUSED, '1);
        put_reg(smlc_pkg::REG_PAT_LOW, low);
        put_reg(smlc_pkg::REG_PAT_HIGH, high);
        put_reg(smlc_pkg::REG_PAT_LEN,
                ({$urandom, $urandom} & ~CFG_W'(31)) | CFG_W'(len_val));
        i_cfg_wr_en <= 1'b0;
        gen_len = (len_val == 0) ? 1 : (len_val > MAX_PAT) ? MAX_PAT : len_val;
    endtask

    function automatic void add_text(int unsigned quota);
        int unsigned cut;
        while (text_q.size() < quota) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    for (int k = 0; k < gen_len; k++) text_q.push_back(pat_b[k]);
                end
                5, 6: begin
                    cut = $urandom_range(0, gen_len - 1);
                    for (int k = 0; k < cut; k++) text_q.push_back(pat_b[k]);
                    text_q.push_back(pat_b[cut] ^ BYTE_W'(1 << $urandom_range(0, 7)));
                end
                7: text_q.push_back(smlc_pkg::NEWLINE);
                8: repeat ($urandom_range(1, 4)) text_q.push_back(BYTE_W'($urandom));
                default: begin
                    repeat ($urandom_range(1, 3))
                        text_q.push_back(pat_b[$urandom_range(0, gen_len - 1)]);
                end
            endcase
        end
    endfunction

    task automatic send_text(bit gappy);
        int unsigned burst;
        burst = $urandom_range(1, 24);
        while (text_q.size() != 0) begin
            i_in_valid     <= 1'b1;
            i_in_text_byte <= text_q.pop_front();
            do @(posedge i_clk); while (!o_in_ready);
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if (gappy && text_q.size() != 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (predictor.pending_count() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // receiver: random stall segments, plus one long hold-off on request
    initial begin
        t_rx_mode    mode;
        int unsigned seg;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                mode = t_rx_mode'($urandom_range(0, 3));
                seg  = $urandom_range(4, 40);
                for (int c = 0; c < seg; c++) begin
                    case (mode)
                        RX_OPEN:   i_out_ready <= 1'b1;
                        RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                        RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                        default:   i_out_ready <= (c % 2 == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int unsigned len_sel;
        predictor = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset pattern: a single zero byte
        text_q = '{8'h00, 8'hFF, 8'h00, smlc_pkg::NEWLINE, 8'h00, smlc_pkg::NEWLINE};
        send_text(1'b0);
        wait_idle();

        // no overlap inside a line, no match across a newline
        foreach (pat_b[k]) pat_b[k] = '0;
        pat_b[0] = 8'h61;
        pat_b[1] = 8'h61;
        load_pattern(LEN_W'(2), 1'b1);
        text_q = '{8'h61, 8'h61, 8'h61, 8'h61, 8'h61, smlc_pkg::NEWLINE, 8'h61,
                   smlc_pkg::NEWLINE};
        send_text(1'b0);
        wait_idle();

        // pattern ending in a newline
        foreach (pat_b[k]) pat_b[k] = '0;
        pat_b[0] = 8'h78;
        pat_b[1] = smlc_pkg::NEWLINE;
        load_pattern(LEN_W'(2), 1'b0);
        text_q = '{8'h78, smlc_pkg::NEWLINE, 8'h78, 8'h78, smlc_pkg::NEWLINE};
        send_text(1'b0);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            foreach (pat_b[k]) pat_b[k] = BYTE_W'($urandom);
            len_sel = 1;
            case (ph)
                1: begin
                    foreach (pat_b[k]) pat_b[k] = '1;
                    len_sel = 16;
                end
                2: begin
                    foreach (pat_b[k]) pat_b[k] = '0;
                    len_sel = 16;
                end
                3: len_sel = $urandom_range(2, 15);
                4: len_sel = 0;
                5: len_sel = 31;
                6: begin
                    foreach (pat_b[k]) pat_b[k] = pat_b[k % 2];
                    len_sel = 4;
                end
                7: begin
                    len_sel = $urandom_range(2, 8);
                    pat_b[len_sel-1] = smlc_pkg::NEWLINE;
                end
                8: begin
                    pat_b[1] = pat_b[0];
                    len_sel = 3;
                end
                default: len_sel = 1;
            endcase
            load_pattern(LEN_W'(len_sel), 1'b0);
            if (ph == 0) long_hold_req = 1'b1;
            add_text(PHASE_ITEMS);
            send_text(ph != 0);
            wait_idle();
        end

        if (predictor.mismatches == 0 && predictor.pending_count() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
design/smlc_pkg.sv
design/smlc_cell.sv
design/substring_match_line_column_unit.sv
bench/testbench.sv
